// File: design/psq_pkg.sv
// Package for the positional sequence store: action and status codes, the
// command record passed from the front end to the back end, and field widths.
// No dependencies.
package psq_pkg;

  // Item field widths
  localparam int ACT_W     = 2;
  localparam int POS_W     = 9;
  localparam int VAL_W     = 32;
  localparam int STAT_W    = 2;
  localparam int CNT_OUT_W = 9;

  // Stream payload widths, padded to whole bytes
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;

  // Action codes on the input stream
  localparam logic [ACT_W-1:0] ACT_READ   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_DONE   = 2'd0;
  localparam logic [STAT_W-1:0] ST_BADPOS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;

  localparam logic [VAL_W-1:0] NEG_ONE = 32'hFFFF_FFFF;

  // Decoded operation; OP_NOP covers the unused action code
  typedef enum logic [1:0] {
    OP_READ,
    OP_INSERT,
    OP_REMOVE,
    OP_NOP
  } op_e;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_PUT,
    BK_DONE
  } back_state_e;

  typedef struct packed {
    op_e              op;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
  } cmd_t;

endpackage

// File: design/psq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module psq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/psq_front.sv
// Front end: takes input items, decodes the action and queues commands.
// Depends on psq_pkg.
module psq_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [psq_pkg::IN_TDATA_W-1:0]     in_data_i,
  output logic                               cmd_valid_o,
  output psq_pkg::cmd_t                      cmd_o,
  input  logic                               cmd_pop_i
);
  import psq_pkg::*;

  localparam int QD = 2;
  localparam int PW = $clog2(QD);
  localparam int FW = $clog2(QD + 1);

  cmd_t            q_mem_q [QD];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [FW-1:0]   fill_q, fill_d;
  logic            push, pop;
  cmd_t            dec_cmd;
  logic [ACT_W-1:0] act;

  // Decode the packed item
  always_comb begin
    act         = in_data_i[ACT_W-1:0];
    dec_cmd.pos = in_data_i[ACT_W +: POS_W];
    dec_cmd.val = in_data_i[ACT_W+POS_W +: VAL_W];
    case (act)
      ACT_READ:   dec_cmd.op = OP_READ;
      ACT_INSERT: dec_cmd.op = OP_INSERT;
      ACT_REMOVE: dec_cmd.op = OP_REMOVE;
      default:    dec_cmd.op = OP_NOP;
    endcase
  end

  assign in_ready_o  = (fill_q != FW'(QD));
  assign cmd_valid_o = (fill_q != '0);
  assign cmd_o       = q_mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + PW'(1) : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + PW'(1) : rd_ptr_q;
    fill_d   = fill_q;
    if (push && !pop) begin
      fill_d = fill_q + FW'(1);
    end else if (pop && !push) begin
      fill_d = fill_q - FW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= dec_cmd;
    end
  end

endmodule

// File: design/psq_back.sv
// Back end: range checks, shifts entries through the element RAM one per
// cycle, and holds the result in an output register. Depends on psq_pkg, psq_ram.
module psq_back #(
  parameter int CAPACITY = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cmd_valid_i,
  input  psq_pkg::cmd_t                   cmd_i,
  output logic                            cmd_pop_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [psq_pkg::OUT_TDATA_W-1:0] out_data_o
);
  import psq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;
  localparam int PADW = OUT_TDATA_W - VAL_W - STAT_W - CNT_OUT_W;

  back_state_e state_q, state_d;

  logic [CW-1:0]        count_q, count_d;
  op_e                  op_q, op_d;
  logic [AW-1:0]        pos_q, pos_d;
  logic [VAL_W-1:0]     val_q, val_d;
  logic [AW-1:0]        cur_q, cur_d;
  logic [CW-1:0]        left_q, left_d;
  logic                 pend_q, pend_d;
  logic [AW-1:0]        pend_addr_q, pend_addr_d;
  logic [VAL_W-1:0]     res_q, res_d;
  logic [STAT_W-1:0]    stat_q, stat_d;
  logic                 out_valid_q, out_valid_d;
  logic [VAL_W-1:0]     out_res_q, out_res_d;
  logic [STAT_W-1:0]    out_stat_q, out_stat_d;
  logic [CNT_OUT_W-1:0] out_cnt_q, out_cnt_d;

  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [VAL_W-1:0] ram_wdata, ram_rdata;

  logic [XW-1:0] pos_x, cnt_x;
  logic          rd_bad, ins_bad, is_full, out_free;

  assign pos_x    = XW'(cmd_i.pos);
  assign cnt_x    = XW'(count_q);
  assign rd_bad   = (pos_x >= cnt_x);
  assign ins_bad  = (pos_x > cnt_x);
  assign is_full  = (count_q >= CW'(CAPACITY));
  assign out_free = !out_valid_q || out_ready_i;

  psq_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.op)
            OP_READ:   state_d = rd_bad ? BK_DONE : BK_RUN;
            OP_INSERT: state_d = (ins_bad || is_full) ? BK_DONE : BK_RUN;
            OP_REMOVE: state_d = rd_bad ? BK_DONE : BK_RUN;
            default:   state_d = BK_DONE;
          endcase
        end
      end
      BK_RUN: begin
        if (left_q == '0) begin
          state_d = (op_q == OP_INSERT) ? BK_PUT : BK_DONE;
        end
      end
      BK_PUT:  state_d = BK_DONE;
      BK_DONE: begin
        if (out_free) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    cmd_pop_o   = 1'b0;
    count_d     = count_q;
    op_d        = op_q;
    pos_d       = pos_q;
    val_d       = val_q;
    cur_d       = cur_q;
    left_d      = left_q;
    pend_d      = pend_q;
    pend_addr_d = pend_addr_q;
    res_d       = res_q;
    stat_d      = stat_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_res_d   = out_res_q;
    out_stat_d  = out_stat_q;
    out_cnt_d   = out_cnt_q;
    ram_we      = 1'b0;
    ram_waddr   = pend_addr_q;
    ram_wdata   = ram_rdata;
    ram_re      = 1'b0;
    ram_raddr   = cur_q;

    case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          op_d      = cmd_i.op;
          pos_d     = AW'(cmd_i.pos);
          val_d     = cmd_i.val;
          pend_d    = 1'b0;
          res_d     = '0;
          stat_d    = ST_DONE;
          case (cmd_i.op)
            OP_READ: begin
              if (rd_bad) begin
                res_d  = NEG_ONE;
                stat_d = ST_BADPOS;
              end else begin
                cur_d  = AW'(cmd_i.pos);
                left_d = CW'(1);
              end
            end
            OP_INSERT: begin
              if (ins_bad) begin
                res_d  = NEG_ONE;
                stat_d = ST_BADPOS;
              end else if (is_full) begin
                res_d  = NEG_ONE;
                stat_d = ST_FULL;
              end else begin
                // walk down from the top entry, moving each one up
                cur_d  = AW'(count_q - CW'(1));
                left_d = CW'(cnt_x - pos_x);
              end
            end
            OP_REMOVE: begin
              if (rd_bad) begin
                res_d  = NEG_ONE;
                stat_d = ST_BADPOS;
              end else begin
                // first read is the removed value, the rest move down
                cur_d  = AW'(cmd_i.pos);
                left_d = CW'(cnt_x - pos_x);
              end
            end
            default: ;
          endcase
        end
      end
      BK_RUN: begin
        // retire the read issued last cycle
        if (pend_q) begin
          case (op_q)
            OP_READ: res_d = ram_rdata;
            OP_REMOVE: begin
              if (pend_addr_q == pos_q) begin
                res_d = ram_rdata;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = pend_addr_q - AW'(1);
              end
            end
            OP_INSERT: begin
              ram_we    = 1'b1;
              ram_waddr = pend_addr_q + AW'(1);
            end
            default: ;
          endcase
        end
        if (left_q != '0) begin
          ram_re      = 1'b1;
          pend_d      = 1'b1;
          pend_addr_d = cur_q;
          cur_d       = (op_q == OP_INSERT) ? cur_q - AW'(1) : cur_q + AW'(1);
          left_d      = left_q - CW'(1);
        end else begin
          pend_d = 1'b0;
          if (op_q == OP_REMOVE) begin
            count_d = count_q - CW'(1);
          end
        end
      end
      BK_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q;
        ram_wdata = val_q;
        count_d   = count_q + CW'(1);
        res_d     = '0;
      end
      BK_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_res_d   = res_q;
          out_stat_d  = stat_q;
          out_cnt_d   = CNT_OUT_W'(count_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    pos_q       <= pos_d;
    val_q       <= val_d;
    cur_q       <= cur_d;
    left_q      <= left_d;
    pend_addr_q <= pend_addr_d;
    res_q       <= res_d;
    stat_q      <= stat_d;
    out_res_q   <= out_res_d;
    out_stat_q  <= out_stat_d;
    out_cnt_q   <= out_cnt_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {PADW'(0), out_cnt_q, out_stat_q, out_res_q};

endmodule

// File: design/positional_sequence_store.sv
// Top level of the positional sequence store: stream ports, front end, back end.
// Depends on psq_pkg, psq_front, psq_back (and psq_ram below it).
//
// Keeps an ordered list of up to CAPACITY signed 32-bit values and runs one
// operation per input item: read at a position, insert a value at a position
// (0..count, later entries move up) or remove at a position (later entries
// close the gap). Every item gives exactly one result item carrying the value
// read or removed (0 after an insert, -1 on a refusal), a status (done, bad
// position, store full) and the element count after the operation. A two-entry
// command queue sits in front, so new items are taken while the back end is
// busy and while a result waits in the output register. The back end is paced by
// the element RAM, which moves one entry per cycle (one read and one write
// port); an insert or remove walks the n = count - position entries from the
// position up. Entries above the count are never read, so the RAM needs no
// clearing after reset.
module positional_sequence_store #(
  parameter int CAPACITY = 256
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // tdata: action[1:0], position[10:2], value[42:11], zero pad[47:43]
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  input  logic [psq_pkg::IN_TDATA_W-1:0]        s_axis_tdata_i,
  // tdata: result_value[31:0], status[33:32], element_count[42:34], pad[47:43]
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  output logic [psq_pkg::OUT_TDATA_W-1:0]       m_axis_tdata_o
);
  import psq_pkg::*;

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  // Decode and queue incoming items
  psq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_data_i   (s_axis_tdata_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // Execute against the element RAM and present results
  psq_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

`ifndef SYNTHESIS
  localparam int ST_LSB  = VAL_W;
  localparam int CNT_LSB = VAL_W + STAT_W;

  // Any refusal reports -1 as its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o &&
    (m_axis_tdata_o[ST_LSB +: STAT_W] == ST_BADPOS ||
     m_axis_tdata_o[ST_LSB +: STAT_W] == ST_FULL)
    |-> m_axis_tdata_o[VAL_W-1:0] == NEG_ONE)
    else $error("refused item did not return -1");

  // A full refusal only happens with the store at capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[ST_LSB +: STAT_W] == ST_FULL
    |-> m_axis_tdata_o[CNT_LSB +: CNT_OUT_W] == CNT_OUT_W'(CAPACITY))
    else $error("full status with count below capacity");
`endif

endmodule
